// ===== design/jsu_pkg.sv =====
// jsu_pkg: shared types, codes and helper functions for the json string unescaper
// no dependencies
`default_nettype none

package jsu_pkg;

  localparam int unsigned JsuQueueDepth = 4;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_STR  = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_HEX0 = 3'd3,
    MODE_HEX1 = 3'd4,
    MODE_HEX2 = 3'd5,
    MODE_HEX3 = 3'd6
  } mode_e;

  typedef enum logic [2:0] {
    KIND_BYTE     = 3'd0,
    KIND_CLOSED   = 3'd1,
    KIND_BAD_ESC  = 3'd2,
    KIND_BAD_HEX  = 3'd3,
    KIND_NO_QUOTE = 3'd4,
    KIND_ENDED    = 3'd5
  } kind_e;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_END  = 1'b1
  } cmd_e;

  // all results caused by one input byte
  typedef struct packed {
    logic [1:0] cnt;
    kind_e      kind;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } group_t;

  function automatic logic is_hex(input logic [7:0] b);
    is_hex = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
             (b >= 8'h41 && b <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] v;
    if (b <= 8'h39) v = b - 8'h30;
    else if (b >= 8'h61) v = b - 8'h57;
    else v = b - 8'h37;
    hex_val = v[3:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/json_string_unescaper.sv =====
// json_string_unescaper: top level, front decoder, group fifo and result expander
// depends on jsu_pkg, jsu_front, jsu_queue, jsu_back
//
//  channel  | handshake        | payload
//  ---------+------------------+------------------------------------
//  input    | push / full      | command_i, text_byte_i
//  results  | pop / empty      | kind_o, data_byte_o, last_o
//
// one input byte is taken per cycle while the group fifo has room
// a byte's results (zero to three) land in the fifo at the edge it is taken
// results leave one per cycle while pop is high; a \u escape yielding three bytes
// holds the fifo head for three transfers, so input rate follows the output drain
// full rises when QueueDepth groups wait; reset empties the fifo and returns to idle
`default_nettype none

module json_string_unescaper #(
  parameter int unsigned QueueDepth = jsu_pkg::JsuQueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic       command_i,
  input  wire logic [7:0] text_byte_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [2:0]      kind_o,
  output logic [7:0]      data_byte_o,
  output logic            last_o
);
  import jsu_pkg::*;

  logic       accept;
  logic       grp_valid;
  group_t     grp, head;
  logic       head_done;
  logic [1:0] idx;

  assign accept = push && !full;

  jsu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .command_i   (command_i),
    .text_byte_i (text_byte_i),
    .grp_valid_o (grp_valid),
    .grp_o       (grp)
  );

  jsu_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (grp_valid),
    .wr_data_i (grp),
    .rd_i      (head_done),
    .rd_data_o (head),
    .full_o    (full),
    .empty_o   (empty)
  );

  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_empty_i (empty),
    .pop_i        (pop),
    .head_done_o  (head_done),
    .idx_o        (idx),
    .kind_o       (kind_o),
    .data_byte_o  (data_byte_o),
    .last_o       (last_o)
  );

  // the walk index never passes the head group's result count
  a_idx_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (idx < head.cnt))
    else $error("result index beyond head group");

  // only decoded bytes come in runs; every other kind ends its group
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o != KIND_BYTE) |-> last_o)
    else $error("status result not marked last");

  // a transfer inside a group leaves the rest of that group waiting
  a_group_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !last_o) |=> (!empty && idx == $past(idx) + 2'd1))
    else $error("group lost in the middle");

  // a group is never stored without results
  a_no_empty_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_valid |-> (grp.cnt != 2'd0 && accept))
    else $error("empty group written");

endmodule

`default_nettype wire

// ===== design/jsu_front.sv =====
// jsu_front: accepts text bytes, tracks the string mode and builds result groups
// depends on jsu_pkg
`default_nettype none

module jsu_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic            command_i,
  input  wire logic [7:0]      text_byte_i,
  output logic                 grp_valid_o,
  output jsu_pkg::group_t      grp_o
);
  import jsu_pkg::*;

  mode_e       mode_q, mode_d;
  logic [11:0] acc_q, acc_d;
  logic        hex_ok;
  logic [3:0]  hv;
  logic [15:0] code;

  assign hex_ok = is_hex(text_byte_i);
  assign hv     = hex_val(text_byte_i);
  assign code   = {acc_q, hv};

  // next state
  always_comb begin
    mode_d = mode_q;
    acc_d  = acc_q;
    if (accept_i) begin
      if (command_i == CMD_END) begin
        mode_d = MODE_IDLE;
      end else begin
        unique case (mode_q) inside
          MODE_STR: begin
            if (text_byte_i == 8'h22) mode_d = MODE_IDLE;
            else if (text_byte_i == 8'h5c) mode_d = MODE_ESC;
          end
          MODE_ESC: begin
            case (text_byte_i) inside
              8'h75: begin
                mode_d = MODE_HEX0;
                acc_d  = '0;
              end
              8'h22, 8'h5c, 8'h2f, 8'h62, 8'h66, 8'h6e, 8'h72, 8'h74: mode_d = MODE_STR;
              default: mode_d = MODE_IDLE;
            endcase
          end
          MODE_HEX0, MODE_HEX1, MODE_HEX2: begin
            if (hex_ok) begin
              acc_d  = {acc_q[7:0], hv};
              mode_d = mode_e'(mode_q + 3'd1);
            end else begin
              mode_d = MODE_IDLE;
            end
          end
          MODE_HEX3: mode_d = hex_ok ? MODE_STR : MODE_IDLE;
          default: begin
            if (text_byte_i == 8'h22) mode_d = MODE_STR;
          end
        endcase
      end
    end
  end

  // result group
  always_comb begin
    grp_o = '{cnt: 2'd0, kind: KIND_BYTE, b0: 8'h00, b1: 8'h00, b2: 8'h00};
    if (command_i == CMD_END) begin
      if (mode_q != MODE_IDLE) begin
        grp_o.cnt  = 2'd1;
        grp_o.kind = KIND_ENDED;
      end
    end else begin
      unique case (mode_q) inside
        MODE_STR: begin
          grp_o.cnt = (text_byte_i == 8'h5c) ? 2'd0 : 2'd1;
          if (text_byte_i == 8'h22) grp_o.kind = KIND_CLOSED;
          else grp_o.b0 = text_byte_i;
        end
        MODE_ESC: begin
          grp_o.cnt = 2'd1;
          case (text_byte_i) inside
            8'h22, 8'h5c, 8'h2f: grp_o.b0 = text_byte_i;
            8'h62: grp_o.b0 = 8'h08;
            8'h66: grp_o.b0 = 8'h0c;
            8'h6e: grp_o.b0 = 8'h0a;
            8'h72: grp_o.b0 = 8'h0d;
            8'h74: grp_o.b0 = 8'h09;
            8'h75: grp_o.cnt = 2'd0;
            default: grp_o.kind = KIND_BAD_ESC;
          endcase
        end
        MODE_HEX0, MODE_HEX1, MODE_HEX2: begin
          if (!hex_ok) begin
            grp_o.cnt  = 2'd1;
            grp_o.kind = KIND_BAD_HEX;
          end
        end
        MODE_HEX3: begin
          if (!hex_ok) begin
            grp_o.cnt  = 2'd1;
            grp_o.kind = KIND_BAD_HEX;
          end else if (code < 16'h0080) begin
            grp_o.cnt = 2'd1;
            grp_o.b0  = code[7:0];
          end else if (code < 16'h0800) begin
            grp_o.cnt = 2'd2;
            grp_o.b0  = 8'hc0 | {3'b000, code[10:6]};
            grp_o.b1  = 8'h80 | {2'b00, code[5:0]};
          end else begin
            grp_o.cnt = 2'd3;
            grp_o.b0  = 8'he0 | {4'h0, code[15:12]};
            grp_o.b1  = 8'h80 | {2'b00, code[11:6]};
            grp_o.b2  = 8'h80 | {2'b00, code[5:0]};
          end
        end
        default: begin
          // whitespace and the opening quote give nothing
          if (!(text_byte_i == 8'h22 || text_byte_i == 8'h20 || text_byte_i == 8'h09 ||
                text_byte_i == 8'h0a || text_byte_i == 8'h0d)) begin
            grp_o.cnt  = 2'd1;
            grp_o.kind = KIND_NO_QUOTE;
          end
        end
      endcase
    end
  end

  assign grp_valid_o = accept_i && (grp_o.cnt != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      acc_q  <= '0;
    end else begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/jsu_queue.sv =====
// jsu_queue: short fifo of result groups between front and back
// depends on jsu_pkg
`default_nettype none

module jsu_queue #(
  parameter int unsigned Depth = jsu_pkg::JsuQueueDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_i,
  input  wire jsu_pkg::group_t  wr_data_i,
  input  wire logic             rd_i,
  output jsu_pkg::group_t       rd_data_o,
  output logic                  full_o,
  output logic                  empty_o
);
  import jsu_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  group_t            mem_q [Depth];
  logic [PtrW-1:0]   wptr_q, rptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wptr_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      if (do_rd) rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
      else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== design/jsu_back.sv =====
// jsu_back: walks the head group and hands out one result per transfer
// depends on jsu_pkg
`default_nettype none

module jsu_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire jsu_pkg::group_t  head_i,
  input  wire logic             head_empty_i,
  input  wire logic             pop_i,
  output logic                  head_done_o,
  output logic [1:0]            idx_o,
  output logic [2:0]            kind_o,
  output logic [7:0]            data_byte_o,
  output logic                  last_o
);
  import jsu_pkg::*;

  logic [1:0] idx_q;
  logic       xfer;

  assign xfer        = pop_i && !head_empty_i;
  assign last_o      = (idx_q == head_i.cnt - 2'd1);
  assign head_done_o = xfer && last_o;
  assign idx_o       = idx_q;
  assign kind_o      = head_i.kind;

  always_comb begin
    case (idx_q)
      2'd0:    data_byte_o = head_i.b0;
      2'd1:    data_byte_o = head_i.b1;
      default: data_byte_o = head_i.b2;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (xfer) begin
      idx_q <= last_o ? 2'd0 : idx_q + 2'd1;
    end
  end

endmodule

`default_nettype wire
